/* src/sfd_pkg.sv */
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types, constants and helpers for the stream frame deframer.
// ----------------------------------------------------------------------------
package sfd_pkg;

  // Connection header layout
  localparam int unsigned HEADER_BYTES = 24;
  localparam logic [4:0]  HEADER_LAST  = 5'(HEADER_BYTES - 1);
  localparam logic [4:0]  MAGIC_BYTES  = 5'd6;
  localparam logic [4:0]  CONN_HI_POS  = 5'd6;
  localparam logic [4:0]  CONN_LO_POS  = 5'd7;
  localparam logic [4:0]  UUID_LO_POS  = 5'd16;
  localparam logic [47:0] MAGIC        = "SSTTCP";

  // ASCII digit range
  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_NINE = 8'h39;

  // Result kinds
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_FRAME   = 2'd1;
  localparam logic [1:0] KIND_PAYLOAD = 2'd2;
  localparam logic [1:0] KIND_ERROR   = 2'd3;

  // Error codes
  localparam logic ERR_BAD_MAGIC  = 1'b0;
  localparam logic ERR_SHORT_LEN  = 1'b1;

  // Default depth of the queue between front and back
  localparam int unsigned SFD_QUEUE_DEPTH = 2;

  // Input transaction
  typedef struct packed {
    logic [7:0] byte_in;
    logic       new_connection;
  } in_item_t;

  // Output transaction
  typedef struct packed {
    logic [1:0]         kind;
    logic signed [7:0]  conn_number;
    logic [63:0]        uuid_high;
    logic [63:0]        uuid_low;
    logic [29:0]        payload_length;
    logic [29:0]        stream_id;
    logic [7:0]         data_byte;
    logic               frame_last;
    logic               error_code;
  } out_item_t;

  // Queue occupancy flags
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Magic byte at header position idx (0..5)
  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [5:0] sh;
    sh = {idx, 3'b000};
    return MAGIC[6'd47 - sh -: 8];
  endfunction

endpackage

/* src/sfd_front.sv */
// ----------------------------------------------------------------------------
// sfd_front
// Byte parser: header check, connection number, UUID capture and
// variable-length length/stream-id decoding. Emits one event per result.
// ----------------------------------------------------------------------------
module sfd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  sfd_pkg::in_item_t item,
  output logic              push,
  output sfd_pkg::out_item_t event_item
);

  typedef enum logic [3:0] {
    PH_HEADER  = 4'b0001,
    PH_LENGTH  = 4'b0010,
    PH_STREAM  = 4'b0100,
    PH_PAYLOAD = 4'b1000
  } phase_t;

  typedef struct packed {
    logic        done;
    logic [2:0]  nbytes;
    logic [29:0] value;
    logic [29:0] accum;
    logic [1:0]  index;
  } varint_res_t;

  // One byte of the 1/2/4-byte variable format
  function automatic varint_res_t varint_feed(input logic [7:0] b,
                                              input logic [29:0] acc,
                                              input logic [1:0] idx);
    varint_res_t r;
    r.done   = 1'b0;
    r.nbytes = 3'd0;
    r.value  = '0;
    r.accum  = acc;
    r.index  = idx;
    case (idx)
      2'd0: begin
        if (!b[7]) begin
          r.done   = 1'b1;
          r.nbytes = 3'd1;
          r.value  = {22'd0, b};
          r.index  = 2'd0;
        end else begin
          r.accum = {23'd0, b[6:0]};
          r.index = 2'd1;
        end
      end
      2'd1: begin
        if (!b[7]) begin
          r.done   = 1'b1;
          r.nbytes = 3'd2;
          r.value  = acc | {15'd0, b, 7'd0};
          r.accum  = '0;
          r.index  = 2'd0;
        end else begin
          r.accum = acc + {16'd0, b[6:0], 7'd0};
          r.index = 2'd2;
        end
      end
      2'd2: begin
        r.accum = acc + {8'd0, b, 14'd0};
        r.index = 2'd3;
      end
      default: begin
        r.done   = 1'b1;
        r.nbytes = 3'd4;
        r.value  = acc + {b, 22'd0};
        r.accum  = '0;
        r.index  = 2'd0;
      end
    endcase
    return r;
  endfunction

  // Parser state
  phase_t            phase, phase_next;
  logic [4:0]        header_index, header_index_next;
  logic signed [7:0] conn_value, conn_value_next;
  logic [63:0]       uuid_high, uuid_high_next;
  logic [63:0]       uuid_low, uuid_low_next;
  logic [29:0]       varint_accum, varint_accum_next;
  logic [1:0]        varint_index, varint_index_next;
  logic [29:0]       frame_len, frame_len_next;
  logic [29:0]       current_stream, current_stream_next;
  logic [29:0]       bytes_left, bytes_left_next;
  logic              rejected, rejected_next;

  // State seen by this byte, after a possible connection restart
  phase_t            c_phase;
  logic [4:0]        c_hidx;
  logic signed [7:0] c_conn;
  logic [63:0]       c_uhi, c_ulo;
  logic [29:0]       c_acc, c_flen, c_sid, c_left;
  logic [1:0]        c_vidx;
  logic              c_rej;

  logic [7:0]        b;
  logic              is_digit;
  logic [7:0]        conn_u;
  varint_res_t       vr;
  logic [29:0]       flen_rem;
  logic [29:0]       left_dec;

  always_comb begin
    b        = item.byte_in;
    is_digit = (b >= sfd_pkg::ASCII_ZERO) && (b <= sfd_pkg::ASCII_NINE);

    // Apply the restart mark ahead of parsing
    c_phase = phase;
    c_hidx  = header_index;
    c_conn  = conn_value;
    c_uhi   = uuid_high;
    c_ulo   = uuid_low;
    c_acc   = varint_accum;
    c_vidx  = varint_index;
    c_flen  = frame_len;
    c_sid   = current_stream;
    c_left  = bytes_left;
    c_rej   = rejected;
    if (item.new_connection) begin
      c_phase = PH_HEADER;
      c_hidx  = '0;
      c_conn  = -8'sd1;
      c_uhi   = '0;
      c_ulo   = '0;
      c_acc   = '0;
      c_vidx  = '0;
      c_flen  = '0;
      c_sid   = '0;
      c_left  = '0;
      c_rej   = 1'b0;
    end

    conn_u   = c_conn;
    vr       = varint_feed(b, c_acc, c_vidx);
    flen_rem = c_flen - {27'd0, vr.nbytes};
    left_dec = c_left - 30'd1;

    phase_next          = c_phase;
    header_index_next   = c_hidx;
    conn_value_next     = c_conn;
    uuid_high_next      = c_uhi;
    uuid_low_next       = c_ulo;
    varint_accum_next   = c_acc;
    varint_index_next   = c_vidx;
    frame_len_next      = c_flen;
    current_stream_next = c_sid;
    bytes_left_next     = c_left;
    rejected_next       = c_rej;

    push       = 1'b0;
    event_item = '0;

    if (accept && !c_rej) begin
      case (c_phase)
        PH_HEADER: begin
          if (c_hidx < sfd_pkg::MAGIC_BYTES) begin
            if (b != sfd_pkg::magic_byte(c_hidx[2:0])) begin
              rejected_next         = 1'b1;
              push                  = 1'b1;
              event_item.kind       = sfd_pkg::KIND_ERROR;
              event_item.error_code = sfd_pkg::ERR_BAD_MAGIC;
            end
          end else if (c_hidx == sfd_pkg::CONN_HI_POS) begin
            conn_value_next = is_digit ? $signed({4'd0, b[3:0]}) : -8'sd1;
          end else if (c_hidx == sfd_pkg::CONN_LO_POS) begin
            if (!c_conn[7] && is_digit) begin
              conn_value_next = $signed((conn_u << 3) + (conn_u << 1) + {4'd0, b[3:0]});
            end
          end else if (c_hidx < sfd_pkg::UUID_LO_POS) begin
            uuid_high_next = {c_uhi[55:0], b};
          end else begin
            uuid_low_next = {c_ulo[55:0], b};
          end

          // Header complete on its last byte, unless the magic failed
          if (!rejected_next) begin
            if (c_hidx >= sfd_pkg::HEADER_LAST) begin
              header_index_next = '0;
              phase_next        = PH_LENGTH;
              push              = 1'b1;
              event_item.kind   = sfd_pkg::KIND_HEADER;
            end else begin
              header_index_next = c_hidx + 5'd1;
            end
          end
        end

        PH_LENGTH: begin
          varint_accum_next = vr.accum;
          varint_index_next = vr.index;
          if (vr.done) begin
            frame_len_next = vr.value;
            phase_next     = PH_STREAM;
          end
        end

        PH_STREAM: begin
          varint_accum_next = vr.accum;
          varint_index_next = vr.index;
          if (vr.done) begin
            current_stream_next = vr.value;
            push                = 1'b1;
            if (c_flen < {27'd0, vr.nbytes}) begin
              rejected_next         = 1'b1;
              event_item.kind       = sfd_pkg::KIND_ERROR;
              event_item.error_code = sfd_pkg::ERR_SHORT_LEN;
            end else begin
              frame_len_next            = flen_rem;
              bytes_left_next           = flen_rem;
              phase_next                = (flen_rem == '0) ? PH_LENGTH : PH_PAYLOAD;
              event_item.kind           = sfd_pkg::KIND_FRAME;
              event_item.payload_length = flen_rem;
              event_item.stream_id      = vr.value;
              event_item.frame_last     = (flen_rem == '0);
            end
          end
        end

        PH_PAYLOAD: begin
          if (c_left != '0) begin
            bytes_left_next = left_dec;
          end
          if (bytes_left_next == '0) begin
            phase_next = PH_LENGTH;
          end
          push                      = 1'b1;
          event_item.kind           = sfd_pkg::KIND_PAYLOAD;
          event_item.payload_length = c_flen;
          event_item.stream_id      = c_sid;
          event_item.data_byte      = b;
          event_item.frame_last     = (bytes_left_next == '0);
        end

        default: begin
          phase_next = PH_HEADER;
        end
      endcase
    end

    // Header fields ride along with every event
    event_item.conn_number = conn_value_next;
    event_item.uuid_high   = uuid_high_next;
    event_item.uuid_low    = uuid_low_next;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEADER;
      header_index   <= '0;
      conn_value     <= -8'sd1;
      uuid_high      <= '0;
      uuid_low       <= '0;
      varint_accum   <= '0;
      varint_index   <= '0;
      frame_len      <= '0;
      current_stream <= '0;
      bytes_left     <= '0;
      rejected       <= 1'b0;
    end else if (accept) begin
      phase          <= phase_next;
      header_index   <= header_index_next;
      conn_value     <= conn_value_next;
      uuid_high      <= uuid_high_next;
      uuid_low       <= uuid_low_next;
      varint_accum   <= varint_accum_next;
      varint_index   <= varint_index_next;
      frame_len      <= frame_len_next;
      current_stream <= current_stream_next;
      bytes_left     <= bytes_left_next;
      rejected       <= rejected_next;
    end
  end

`ifndef SYNTHESIS
  // A rejected connection stays silent until the next restart
  a_rejected_silent: assert property (@(posedge clk) disable iff (rst)
    accept && rejected && !item.new_connection |-> !push)
    else $error("event produced on a rejected connection");

  // Last header byte moves the parser to the length field
  a_header_done: assert property (@(posedge clk) disable iff (rst)
    accept && !item.new_connection && !rejected && phase == PH_HEADER &&
    header_index == sfd_pkg::HEADER_LAST |=> phase == PH_LENGTH)
    else $error("header end did not enter length phase");

  // Payload bytes only belong to frames with a payload
  a_payload_len: assert property (@(posedge clk) disable iff (rst)
    push && event_item.kind == sfd_pkg::KIND_PAYLOAD |-> event_item.payload_length != '0)
    else $error("payload byte in an empty frame");
`endif

endmodule

/* src/sfd_queue.sv */
// ----------------------------------------------------------------------------
// sfd_queue
// Small FIFO between the parser and the output stage.
// ----------------------------------------------------------------------------
module sfd_queue #(
  parameter int unsigned DEPTH = sfd_pkg::SFD_QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  sfd_pkg::out_item_t  push_data,
  input  logic                pop,
  output sfd_pkg::out_item_t  pop_data,
  output sfd_pkg::q_status_t  status
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  sfd_pkg::out_item_t entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;

  assign status.full  = (count == CNT_FULL);
  assign status.empty = (count == '0);
  assign pop_data     = entries[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !status.full || pop)
    else $error("queue write while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !status.empty)
    else $error("queue read while empty");
`endif

endmodule

/* src/sfd_back.sv */
// ----------------------------------------------------------------------------
// sfd_back
// Output stage: takes events from the queue into the result register.
// ----------------------------------------------------------------------------
module sfd_back (
  input  logic                clk,
  input  logic                rst,
  input  sfd_pkg::q_status_t  status,
  input  sfd_pkg::out_item_t  head,
  output logic                pop,
  output logic                result_valid,
  input  logic                result_ready,
  output sfd_pkg::out_item_t  result
);

  // Load when the register is free or being drained this cycle
  assign pop = !status.empty && (!result_valid || result_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pop) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result <= head;
    end
  end

`ifndef SYNTHESIS
  // A held result is never overwritten by the queue
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |-> !pop)
    else $error("pending result overwritten");
`endif

endmodule

/* src/stream_frame_deframer_core.sv */
// ----------------------------------------------------------------------------
// stream_frame_deframer_core
// Connection deframer: header check, frame length/stream-id decode and
// per-byte payload results.
// ----------------------------------------------------------------------------
// Takes one connection byte per clock while the internal queue has room and
// returns at most one result per byte. Each byte is parsed by the front
// parser, whose one-step state update is what sets the one-byte-per-cycle
// rate. A result passes from the parser through the queue into the result
// register, and stalls on the result side back up through the queue (default
// two entries) before item_ready drops. Header bytes other than the last
// (unless the magic fails), the length bytes and the stream-id bytes other
// than the last give no result.
module stream_frame_deframer_core #(
  parameter int unsigned QUEUE_DEPTH = sfd_pkg::SFD_QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  sfd_pkg::in_item_t   item,
  output logic                result_valid,
  input  logic                result_ready,
  output sfd_pkg::out_item_t  result
);

  logic               accept;
  logic               push;
  logic               pop;
  sfd_pkg::out_item_t event_item;
  sfd_pkg::out_item_t head;
  sfd_pkg::q_status_t status;

  assign item_ready = !status.full;
  assign accept     = item_valid && item_ready;

  // Parser
  sfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .item       (item),
    .push       (push),
    .event_item (event_item)
  );

  // Event queue
  sfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (event_item),
    .pop       (pop),
    .pop_data  (head),
    .status    (status)
  );

  // Output register
  sfd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .status       (status),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stream frame deframer core.
// ----------------------------------------------------------------------------
// Feeds connection bytes through the input handshake and compares every
// result against a cycle-free software parser of the same byte stream. A
// short directed sequence hits the header and frame corner cases. Random
// connections follow under several traffic mixes, including a long hold
// on the result side that backs the block up onto its input.
module tb;

  localparam int RESET_CYCLES = 6;
  localparam int ITEM_TARGET  = 1000;
  localparam int PHASE_BYTES  = 125;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 20;

  typedef enum logic [1:0] {P_HEADER, P_LENGTH, P_STREAM, P_PAYLOAD} parse_state_t;
  typedef enum logic [2:0] {
    MODE_FREE, MODE_SEND_IDLE, MODE_RECV_STALL, MODE_BOTH, MODE_PRESSURE
  } traffic_mode_t;

  // Parser mirror: tracks connection state and holds the results still due
  class frame_ledger;
    parse_state_t         stage;
    int                   hdr_pos;
    shortint              conn_val;
    logic [63:0]          uuid_hi, uuid_lo;
    logic [31:0]          vacc;
    logic [1:0]           vpos;
    logic [29:0]          flen, cur_sid, left;
    bit                   dead;
    sfd_pkg::out_item_t   pending[$];
    int                   parsed, checked, errors;
    int                   kind_count[4];

    function new();
      restart();
    endfunction

    function void restart();
      stage    = P_HEADER;
      hdr_pos  = 0;
      conn_val = -1;
      uuid_hi  = '0;
      uuid_lo  = '0;
      vacc     = '0;
      vpos     = '0;
      flen     = '0;
      cur_sid  = '0;
      left     = '0;
      dead     = 1'b0;
    endfunction

    function void queue_result(logic [1:0] kind, logic [29:0] plen, logic [29:0] sid_v,
                               logic [7:0] data, logic last, logic err);
      sfd_pkg::out_item_t e;
      e.kind           = kind;
      e.conn_number    = conn_val[7:0];
      e.uuid_high      = uuid_hi;
      e.uuid_low       = uuid_lo;
      e.payload_length = plen;
      e.stream_id      = sid_v;
      e.data_byte      = data;
      e.frame_last     = last;
      e.error_code     = err;
      pending.push_back(e);
    endfunction

    // Variable-length field decoder; returns byte count when complete, else 0
    function int unsigned feed_varint(input logic [7:0] b, output logic [29:0] v);
      logic [31:0] bw;
      logic [31:0] sum;
      bw = {24'd0, b};
      v  = '0;
      case (vpos)
        2'd0: begin
          if (!b[7]) begin
            v = bw[29:0];
            return 1;
          end
          vacc = {25'd0, b[6:0]};
          vpos = 2'd1;
          return 0;
        end
        2'd1: begin
          if (!b[7]) begin
            sum  = vacc | (bw << 7);
            v    = sum[29:0];
            vpos = 2'd0;
            vacc = '0;
            return 2;
          end
          vacc = vacc + ({25'd0, b[6:0]} << 7);
          vpos = 2'd2;
          return 0;
        end
        2'd2: begin
          vacc = vacc + (bw << 14);
          vpos = 2'd3;
          return 0;
        end
        default: begin
          sum  = vacc + (bw << 22);
          v    = sum[29:0];
          vpos = 2'd0;
          vacc = '0;
          return 4;
        end
      endcase
    endfunction

    function bit is_digit(logic [7:0] b);
      return b >= sfd_pkg::ASCII_ZERO && b <= sfd_pkg::ASCII_NINE;
    endfunction

    // Advance the parser by one accepted byte
    function void take_byte(sfd_pkg::in_item_t it);
      logic [7:0]  b;
      logic [29:0] v;
      int unsigned n;
      b = it.byte_in;
      if (it.new_connection) restart();
      if (dead) return;
      parsed++;
      case (stage)
        P_HEADER: begin
          if (hdr_pos < sfd_pkg::MAGIC_BYTES) begin
            if (b != sfd_pkg::MAGIC[47 - 8*hdr_pos -: 8]) begin
              dead = 1'b1;
              queue_result(sfd_pkg::KIND_ERROR, '0, '0, '0, 1'b0, sfd_pkg::ERR_BAD_MAGIC);
              return;
            end
          end else if (hdr_pos == sfd_pkg::CONN_HI_POS) begin
            conn_val = is_digit(b) ? shortint'(b - sfd_pkg::ASCII_ZERO) : -1;
          end else if (hdr_pos == sfd_pkg::CONN_LO_POS) begin
            if (conn_val >= 0 && is_digit(b))
              conn_val = conn_val * 10 + shortint'(b - sfd_pkg::ASCII_ZERO);
          end else if (hdr_pos < sfd_pkg::UUID_LO_POS) begin
            uuid_hi = {uuid_hi[55:0], b};
          end else begin
            uuid_lo = {uuid_lo[55:0], b};
          end
          if (hdr_pos == sfd_pkg::HEADER_BYTES - 1) begin
            hdr_pos = 0;
            stage   = P_LENGTH;
            queue_result(sfd_pkg::KIND_HEADER, '0, '0, '0, 1'b0, 1'b0);
          end else begin
            hdr_pos++;
          end
        end
        P_LENGTH: begin
          n = feed_varint(b, v);
          if (n != 0) begin
            flen  = v;
            stage = P_STREAM;
          end
        end
        P_STREAM: begin
          n = feed_varint(b, v);
          if (n == 0) return;
          cur_sid = v;
          if (flen < n) begin
            dead = 1'b1;
            queue_result(sfd_pkg::KIND_ERROR, '0, '0, '0, 1'b0, sfd_pkg::ERR_SHORT_LEN);
            return;
          end
          flen  = flen - n;
          left  = flen;
          stage = (left == 0) ? P_LENGTH : P_PAYLOAD;
          queue_result(sfd_pkg::KIND_FRAME, flen, cur_sid, '0, left == 0, 1'b0);
        end
        default: begin
          if (left != 0) left--;
          if (left == 0) stage = P_LENGTH;
          queue_result(sfd_pkg::KIND_PAYLOAD, flen, cur_sid, b, left == 0, 1'b0);
        end
      endcase
    endfunction

    function bit field_ok(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        if (errors < MAX_REPORTS)
          $display("%0t: result %0d %s mismatch: expected %h, actual %h",
                   $time, checked, name, want, got);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    // Compare one result transaction with the oldest outstanding one
    function void match_result(sfd_pkg::out_item_t got);
      sfd_pkg::out_item_t want;
      bit                 ok;
      if (pending.size() == 0) begin
        if (errors < MAX_REPORTS)
          $display("%0t: stray result: expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      ok = 1'b1;
      ok &= field_ok("kind", want.kind, got.kind);
      ok &= field_ok("conn_number", want.conn_number, got.conn_number);
      ok &= field_ok("uuid_high", want.uuid_high, got.uuid_high);
      ok &= field_ok("uuid_low", want.uuid_low, got.uuid_low);
      ok &= field_ok("payload_length", want.payload_length, got.payload_length);
      ok &= field_ok("stream_id", want.stream_id, got.stream_id);
      ok &= field_ok("data_byte", want.data_byte, got.data_byte);
      ok &= field_ok("frame_last", want.frame_last, got.frame_last);
      ok &= field_ok("error_code", want.error_code, got.error_code);
      if (!ok) errors++;
      else kind_count[want.kind]++;
      checked++;
    endfunction
  endclass

  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               item_valid   = 1'b0;
  logic               item_ready;
  sfd_pkg::in_item_t  item         = '0;
  logic               result_valid;
  logic               result_ready = 1'b0;
  sfd_pkg::out_item_t result;
  traffic_mode_t      mode         = MODE_FREE;
  int                 conn_count   = 0;
  int                 quiet_cycles = 0;
  frame_ledger        ledger       = new();

  stream_frame_deframer_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Random byte leaning toward the all-zero and all-one extremes
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Any encoding wide enough for the value, short forms included
  function automatic int pick_format(logic [29:0] v);
    int unsigned r;
    r = $urandom_range(5);
    if (v < 128) return (r < 4) ? 1 : (r == 4) ? 2 : 4;
    if (v < 16384) return (r < 4) ? 2 : 4;
    return 4;
  endfunction

  // One input transaction; optional idle gap first, valid held until taken
  task automatic send_byte(input logic [7:0] b, input logic fresh);
    sfd_pkg::in_item_t it;
    int unsigned       pct;
    it.byte_in        = b;
    it.new_connection = fresh;
    pct = (mode == MODE_SEND_IDLE) ? 69 : (mode == MODE_BOTH) ? 7 : 0;
    if ($urandom_range(99) < pct) begin
      item_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < pct);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (item_ready !== 1'b1);
    ledger.take_byte(it);
  endtask

  task automatic send_varint(input logic [29:0] v, input int nb);
    if (nb == 1) begin
      send_byte({1'b0, v[6:0]}, 1'b0);
    end else if (nb == 2) begin
      send_byte({1'b1, v[6:0]}, 1'b0);
      send_byte({1'b0, v[13:7]}, 1'b0);
    end else begin
      send_byte({1'b1, v[6:0]}, 1'b0);
      send_byte({1'b1, v[13:7]}, 1'b0);
      send_byte(v[21:14], 1'b0);
      send_byte(v[29:22], 1'b0);
    end
  endtask

  // Connection header; may corrupt the magic or stop part way
  task automatic send_header(input bit fresh, input bit allow_bad, output bit ok);
    logic [7:0] hdr [sfd_pkg::HEADER_BYTES];
    int         bad_pos;
    int         abort_pos;
    int         style;
    bad_pos   = -1;
    abort_pos = -1;
    conn_count++;
    for (int i = 0; i < 6; i++) hdr[i] = sfd_pkg::MAGIC[47 - 8*i -: 8];
    for (int i = 6; i < 8; i++)
      hdr[i] = ($urandom_range(9) < 8) ? 8'(sfd_pkg::ASCII_ZERO + $urandom_range(9))
                                       : pick_byte();
    style = $urandom_range(9);
    for (int i = 8; i < sfd_pkg::HEADER_BYTES; i++)
      hdr[i] = (style == 0) ? 8'h00 : (style == 1) ? 8'hFF : 8'($urandom);
    if (allow_bad && $urandom_range(99) < 8) begin
      bad_pos = $urandom_range(5);
      hdr[bad_pos] ^= 8'($urandom_range(1, 255));
    end else if (allow_bad && $urandom_range(99) < 4) begin
      abort_pos = $urandom_range(6, sfd_pkg::HEADER_BYTES - 2);
    end
    for (int i = 0; i < sfd_pkg::HEADER_BYTES; i++) begin
      send_byte(hdr[i], fresh && i == 0);
      if (i == bad_pos) begin
        // block now ignores the rest of the connection
        repeat ($urandom_range(2)) send_byte(pick_byte(), 1'b0);
        ok = 1'b0;
        return;
      end
      if (i == abort_pos) begin
        ok = 1'b0;
        return;
      end
    end
    ok = 1'b1;
  endtask

  // One frame: length, stream id, payload; forced_plen < 0 picks at random
  task automatic send_frame(input int forced_plen, output bit ok);
    logic [29:0] sid_v, len_v, plen;
    int          sid_n;
    int unsigned r;
    bit          cut;
    cut = 1'b0;
    case ($urandom_range(2))
      0: begin
        sid_n = 1;
        sid_v = 30'($urandom_range(127));
      end
      1: begin
        sid_n = 2;
        sid_v = 30'($urandom_range(16383));
      end
      default: begin
        sid_n = 4;
        r = $urandom_range(9);
        sid_v = (r == 0) ? '1 : (r == 1) ? '0 : 30'($urandom);
      end
    endcase
    if (forced_plen >= 0) begin
      len_v = 30'(forced_plen + sid_n);
    end else begin
      r = $urandom_range(99);
      if (r < 5)       len_v = 30'($urandom_range(sid_n - 1));
      else if (r < 9) begin
        // huge frame, abandoned after a few bytes
        cut   = 1'b1;
        len_v = ($urandom_range(3) == 0) ? '1 : (30'($urandom) | 30'h2000_0000);
      end
      else if (r < 25) len_v = 30'(sid_n);
      else             len_v = 30'(sid_n + $urandom_range(1, 12));
    end
    send_varint(len_v, pick_format(len_v));
    send_varint(sid_v, sid_n);
    if (len_v < sid_n) begin
      ok = 1'b0;
      return;
    end
    plen = len_v - 30'(sid_n);
    if (cut) begin
      repeat ($urandom_range(5)) send_byte(pick_byte(), 1'b0);
      ok = 1'b0;
      return;
    end
    for (int i = 0; i < plen; i++) send_byte(pick_byte(), 1'b0);
    ok = 1'b1;
  endtask

  // Mostly well-formed connections, some pure noise
  task automatic send_connection();
    bit ok;
    int n;
    if ($urandom_range(99) < 5) begin
      n = $urandom_range(1, 40);
      for (int i = 0; i < n; i++)
        send_byte(8'($urandom), i == 0 || $urandom_range(19) == 0);
      return;
    end
    send_header(1'b1, 1'b1, ok);
    if (!ok) return;
    n = $urandom_range(1, 6);
    repeat (n) begin
      send_frame(-1, ok);
      if (!ok) return;
    end
  endtask

  // Result side: random stalls per traffic mix, one long hold under pressure
  initial begin : receiver
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (mode == MODE_PRESSURE && !held) begin
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held = 1'b1;
      end
      result_ready <= ($urandom_range(99) >=
                       ((mode == MODE_RECV_STALL) ? 69 : (mode == MODE_BOTH) ? 7 : 0));
    end
  end

  // Check each result transaction
  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1 && result_ready)
      ledger.match_result(result);
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout, no transaction for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, ledger.pending.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    traffic_mode_t order [4];
    int            phase_idx;
    int            start;
    int            goal;
    bit            ok;
    order = '{MODE_FREE, MODE_SEND_IDLE, MODE_RECV_STALL, MODE_BOTH};
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Bytes before any connection flag, ignored byte, bad first byte
    send_byte("S", 1'b0);
    send_byte("X", 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte("Q", 1'b1);
    // Full header with the largest connection number
    for (int i = 0; i < sfd_pkg::HEADER_BYTES; i++)
      send_byte((i < 6) ? sfd_pkg::MAGIC[47 - 8*i -: 8] : (i < 8) ? sfd_pkg::ASCII_NINE :
                (i < 16) ? 8'hFF : 8'h00, i == 0);
    // Empty-payload frame, then a length shorter than the stream id
    send_byte(8'h01, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);

    // Random connections across the traffic mixes
    goal      = ledger.parsed + ITEM_TARGET;
    phase_idx = 0;
    while (ledger.parsed < goal) begin
      if (phase_idx == 4) begin
        mode <= MODE_PRESSURE;
        send_header(1'b1, 1'b0, ok);
        send_frame(150, ok);
      end
      mode <= order[phase_idx % 4];
      start = ledger.parsed;
      while (ledger.parsed - start < PHASE_BYTES) send_connection();
      phase_idx++;
    end
    item_valid <= 1'b0;
    mode       <= MODE_FREE;

    // Drain, then watch for stray results
    while (ledger.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d parsed bytes over %0d connections in %0d traffic phases,",
             ledger.parsed, conn_count, phase_idx);
    $display("checking %0d results: %0d headers, %0d frames, %0d payload, %0d errors.",
             ledger.checked, ledger.kind_count[sfd_pkg::KIND_HEADER],
             ledger.kind_count[sfd_pkg::KIND_FRAME],
             ledger.kind_count[sfd_pkg::KIND_PAYLOAD],
             ledger.kind_count[sfd_pkg::KIND_ERROR]);
    if (ledger.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
src/sfd_pkg.sv
src/sfd_front.sv
src/sfd_queue.sv
src/sfd_back.sv
src/stream_frame_deframer_core.sv
tb/sv/tb.sv
